### rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define UE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
`define UE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define UE_ASSERT(lbl, prop)
`define UE_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

### rtl/ue2u_pkg.sv
// shared types and constants for the unicode escape decoder
`timescale 1ns / 1ps
`default_nettype none

package ue2u_pkg;

    localparam int UE_MAX_OUT     = 5;
    localparam int UE_QUEUE_DEPTH = 4;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_ESC  = 2'd1;
    localparam t_status ST_PAIR = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_BS,
        PH_D1A,
        PH_D1B,
        PH_D1C,
        PH_D1D,
        PH_WBS,
        PH_WU,
        PH_D2A,
        PH_D2B,
        PH_D2C,
        PH_D2D
    } t_phase;

    typedef logic [UE_MAX_OUT-1:0][7:0] t_bytes;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        t_status    status;
        logic       out_last;
    } t_out_beat;

    typedef struct packed {
        t_bytes     bytes;
        logic [2:0] cnt;
        logic       last;
        t_status    status;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/unicode_escape_to_utf8.sv
// top level of the \uXXXX escape to utf-8 decoder
//
//  channel  valid          stall          payload
//  in       i_in_valid     o_in_stall     i_in_data  (in_byte, in_last)
//  out      o_out_valid    i_out_stall    o_out_data (out_byte, out_valid, status, out_last)
//
// one input beat accepted per cycle while the command queue has room
// each beat gives zero to five result beats, played out one per cycle while the output is not stalled
// each result beat is registered in the command queue and then in the output register
// input stalls only when the QUEUE_DEPTH-entry command queue is full
// synchronous reset, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module unicode_escape_to_utf8 import ue2u_pkg::*; #(
    parameter int QUEUE_DEPTH = UE_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_data,
    input  logic      i_out_stall
);

    logic w_full;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;

    ue2u_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    ue2u_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_cmd),
        .i_pop   (w_pop)
    );

    ue2u_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cmd   (w_q_cmd),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

### rtl/ue2u_front.sv
// front end: escape parser that turns each accepted input beat into at most one output command
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ue2u_front import ue2u_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_data,
    output logic     o_stall,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam logic [7:0]  CH_BSL       = 8'h5C;
    localparam logic [7:0]  CH_U         = 8'h75;
    localparam logic [5:0]  HI_TAG       = 6'b110110;
    localparam logic [5:0]  LO_TAG       = 6'b110111;
    localparam logic [20:0] CP_1B_MAX    = 21'h00007F;
    localparam logic [20:0] CP_2B_MAX    = 21'h0007FF;
    localparam logic [20:0] CP_3B_MAX    = 21'h00FFFF;
    localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [7:0]  LEAD2        = 8'hC0;
    localparam logic [7:0]  LEAD3        = 8'hE0;
    localparam logic [7:0]  LEAD4        = 8'hF0;
    localparam logic [7:0]  CONT         = 8'h80;

    t_phase          r_phase, n_phase;
    logic [15:0]     r_hex, n_hex;
    logic            r_bad, n_bad;
    logic [2:0][7:0] r_held, n_held;
    logic [9:0]      r_high, n_high;
    logic            r_failed, n_failed;
    t_status         r_code, n_code;

    logic            w_acc;
    logic [7:0]      w_c;
    logic            w_last;
    logic            w_dig_ok;
    logic [3:0]      w_dig;
    logic [15:0]     w_hex;
    logic            w_bad;
    logic            w_is_hi;
    logic            w_is_lo;
    logic [20:0]     w_cp;
    logic [2:0]      w_ecnt;
    logic [3:0][7:0] w_ebytes;

    t_phase          w_after;
    logic            w_sfail;
    t_status         w_scode;
    logic [2:0]      w_scnt;
    t_bytes          w_sbytes;

    assign w_c     = i_data.in_byte;
    assign w_last  = i_data.in_last;
    assign o_stall = i_full;
    assign w_acc   = i_valid && !i_full;

    // digit decode and code point
    always_comb begin
        w_dig_ok = 1'b0;
        w_dig    = 4'h0;
        if (w_c >= 8'h30 && w_c <= 8'h39) begin
            w_dig_ok = 1'b1;
            w_dig    = w_c[3:0];
        end else if ((w_c >= 8'h61 && w_c <= 8'h66) || (w_c >= 8'h41 && w_c <= 8'h46)) begin
            w_dig_ok = 1'b1;
            w_dig    = w_c[3:0] + 4'd9;
        end
        w_hex   = {r_hex[11:0], w_dig};
        w_bad   = r_bad || !w_dig_ok;
        w_is_hi = (w_hex[15:10] == HI_TAG);
        w_is_lo = (w_hex[15:10] == LO_TAG);
        if (r_phase == PH_D2D) begin
            w_cp = {1'b0, r_high, w_hex[9:0]} + CP_SUPP_BASE;
        end else begin
            w_cp = {5'b0, w_hex};
        end
    end

    // utf-8 encoder
    always_comb begin
        w_ecnt   = 3'd0;
        w_ebytes = '0;
        if (w_cp <= CP_1B_MAX) begin
            w_ecnt      = 3'd1;
            w_ebytes[0] = w_cp[7:0];
        end else if (w_cp <= CP_2B_MAX) begin
            w_ecnt      = 3'd2;
            w_ebytes[0] = LEAD2 | {3'b0, w_cp[10:6]};
            w_ebytes[1] = CONT | {2'b0, w_cp[5:0]};
        end else if (w_cp <= CP_3B_MAX) begin
            w_ecnt      = 3'd3;
            w_ebytes[0] = LEAD3 | {4'b0, w_cp[15:12]};
            w_ebytes[1] = CONT | {2'b0, w_cp[11:6]};
            w_ebytes[2] = CONT | {2'b0, w_cp[5:0]};
        end else begin
            w_ecnt      = 3'd4;
            w_ebytes[0] = LEAD4 | {5'b0, w_cp[20:18]};
            w_ebytes[1] = CONT | {2'b0, w_cp[17:12]};
            w_ebytes[2] = CONT | {2'b0, w_cp[11:6]};
            w_ebytes[3] = CONT | {2'b0, w_cp[5:0]};
        end
    end

    // one character step
    always_comb begin
        w_after  = r_phase;
        w_sfail  = 1'b0;
        w_scode  = ST_ESC;
        w_scnt   = 3'd0;
        w_sbytes = '0;
        if (!r_failed) begin
            case (r_phase)
                PH_IDLE: begin
                    if (w_c == CH_BSL) begin
                        w_after = PH_BS;
                    end else begin
                        w_sbytes[0] = w_c;
                        w_scnt      = 3'd1;
                    end
                end
                PH_BS: begin
                    if (w_c == CH_U) begin
                        w_after = PH_D1A;
                    end else if (w_c == CH_BSL) begin
                        w_sbytes[0] = CH_BSL;
                        w_scnt      = 3'd1;
                        w_after     = PH_BS;
                    end else begin
                        w_sbytes[0] = CH_BSL;
                        w_sbytes[1] = w_c;
                        w_scnt      = 3'd2;
                        w_after     = PH_IDLE;
                    end
                end
                PH_D1A: w_after = PH_D1B;
                PH_D1B: w_after = PH_D1C;
                PH_D1C: w_after = PH_D1D;
                PH_D1D: begin
                    if (w_bad || w_is_lo) begin
                        w_sfail = 1'b1;
                        w_after = PH_IDLE;
                    end else if (w_is_hi) begin
                        w_after = PH_WBS;
                    end else begin
                        w_sbytes[3:0] = w_ebytes;
                        w_scnt        = w_ecnt;
                        w_after       = PH_IDLE;
                    end
                end
                PH_WBS: begin
                    if (w_c == CH_BSL) begin
                        w_after = PH_WU;
                    end else begin
                        w_sfail = 1'b1;
                        w_after = PH_IDLE;
                    end
                end
                PH_WU: begin
                    if (w_c == CH_U) begin
                        w_after = PH_D2A;
                    end else begin
                        w_sfail = 1'b1;
                        w_after = PH_IDLE;
                    end
                end
                PH_D2A: w_after = PH_D2B;
                PH_D2B: w_after = PH_D2C;
                PH_D2C: w_after = PH_D2D;
                PH_D2D: begin
                    w_after = PH_IDLE;
                    if (w_bad || !w_is_lo) begin
                        w_sfail = 1'b1;
                        w_scode = ST_PAIR;
                    end else begin
                        w_sbytes[3:0] = w_ebytes;
                        w_scnt        = w_ecnt;
                    end
                end
                default: w_after = PH_IDLE;
            endcase
        end
    end

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_hex    = r_hex;
        n_bad    = r_bad;
        n_held   = r_held;
        n_high   = r_high;
        n_failed = r_failed;
        n_code   = r_code;
        if (w_acc && !r_failed) begin
            case (r_phase)
                PH_BS, PH_WU: begin
                    n_hex = '0;
                    n_bad = 1'b0;
                end
                PH_D1A, PH_D1B, PH_D1C, PH_D2A, PH_D2B, PH_D2C: begin
                    n_hex = w_hex;
                    n_bad = w_bad;
                end
                PH_D1D: begin
                    n_hex  = w_hex;
                    n_bad  = w_bad;
                    n_high = w_hex[9:0];
                end
                default: begin
                    n_hex = r_hex;
                end
            endcase
            case (r_phase)
                PH_D1A:  n_held[0] = w_c;
                PH_D1B:  n_held[1] = w_c;
                PH_D1C:  n_held[2] = w_c;
                default: n_held    = r_held;
            endcase
        end
        if (w_acc) begin
            if (w_last) begin
                n_phase  = PH_IDLE;
                n_failed = 1'b0;
                n_code   = ST_OK;
                n_hex    = '0;
                n_bad    = 1'b0;
                n_high   = '0;
            end else begin
                n_phase = w_after;
                if (w_sfail) begin
                    n_failed = 1'b1;
                    n_code   = w_scode;
                end
            end
        end
    end

    // command to the queue
    always_comb begin
        o_cmd        = '0;
        o_cmd.last   = w_last;
        o_cmd.status = ST_OK;
        o_cmd.bytes  = w_sbytes;
        o_cmd.cnt    = w_scnt;
        o_push       = w_acc && (w_last || (w_scnt != 3'd0));
        if (w_last) begin
            if (r_failed || w_sfail) begin
                o_cmd.bytes  = '0;
                o_cmd.cnt    = 3'd0;
                o_cmd.status = r_failed ? r_code : w_scode;
            end else begin
                case (w_after)
                    PH_IDLE: begin
                        o_cmd.cnt = w_scnt;
                    end
                    PH_BS: begin
                        o_cmd.bytes[w_scnt] = CH_BSL;
                        o_cmd.cnt           = w_scnt + 3'd1;
                    end
                    PH_D1A, PH_D1B, PH_D1C, PH_D1D: begin
                        o_cmd.bytes[0] = CH_BSL;
                        o_cmd.bytes[1] = CH_U;
                        o_cmd.bytes[2] = n_held[0];
                        o_cmd.bytes[3] = n_held[1];
                        o_cmd.bytes[4] = n_held[2];
                        case (w_after)
                            PH_D1A:  o_cmd.cnt = 3'd2;
                            PH_D1B:  o_cmd.cnt = 3'd3;
                            PH_D1C:  o_cmd.cnt = 3'd4;
                            default: o_cmd.cnt = 3'd5;
                        endcase
                    end
                    default: begin
                        // surrogate pair still open at the end
                        o_cmd.bytes  = '0;
                        o_cmd.cnt    = 3'd0;
                        o_cmd.status = ST_ESC;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_failed <= 1'b0;
            r_code   <= ST_OK;
            r_bad    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_failed <= n_failed;
            r_code   <= n_code;
            r_bad    <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hex  <= n_hex;
        r_held <= n_held;
        r_high <= n_high;
    end

    `UE_ASSERT(a_failed_idle, !r_failed || r_phase == PH_IDLE)

endmodule

`default_nettype wire

### rtl/ue2u_fifo.sv
// command queue between the parser and the output sequencer
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ue2u_fifo import ue2u_pkg::*; #(
    parameter int DEPTH = UE_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `UE_ASSERT(a_no_push_full, !(i_push && o_full))
    `UE_ASSERT(a_no_pop_empty, !(i_pop && !o_valid))

endmodule

`default_nettype wire

### rtl/ue2u_back.sv
// back end: plays each command out as result beats into the output register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ue2u_back import ue2u_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_beat o_data,
    input  logic      i_stall
);

    logic       r_o_valid, n_o_valid;
    t_out_beat  r_o_data, n_o_data;
    logic [2:0] r_idx, n_idx;
    logic       w_adv;
    logic       w_final;

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    always_comb begin
        w_adv   = !r_o_valid || !i_stall;
        w_final = (i_cmd.cnt == 3'd0) || (r_idx == i_cmd.cnt - 3'd1);
        o_pop   = i_valid && w_adv && w_final;
    end

    always_comb begin
        n_o_valid = r_o_valid;
        n_o_data  = r_o_data;
        n_idx     = r_idx;
        if (w_adv) begin
            n_o_valid = i_valid;
            if (i_valid) begin
                n_idx = w_final ? 3'd0 : r_idx + 3'd1;
                if (i_cmd.cnt == 3'd0) begin
                    n_o_data.out_byte  = 8'h00;
                    n_o_data.out_valid = 1'b0;
                    n_o_data.status    = i_cmd.status;
                    n_o_data.out_last  = 1'b1;
                end else begin
                    n_o_data.out_byte  = i_cmd.bytes[r_idx];
                    n_o_data.out_valid = 1'b1;
                    n_o_data.status    = ST_OK;
                    n_o_data.out_last  = i_cmd.last && w_final;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_idx     <= 3'd0;
        end else begin
            r_o_valid <= n_o_valid;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_data <= n_o_data;
    end

    `UE_ASSERT_IMP(a_bare_is_last, r_o_valid && !r_o_data.out_valid, r_o_data.out_last)
    `UE_ASSERT_IMP(a_status_bare, r_o_valid && r_o_data.status != ST_OK, !r_o_data.out_valid)

endmodule

`default_nettype wire

### bench/unicode_escape_to_utf8_tb.sv
// testbench for the unicode escape decoder: directed and random strings checked against a predictor
`timescale 1ns / 1ps

module unicode_escape_to_utf8_tb;
    import ue2u_pkg::*;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;

    unicode_escape_to_utf8 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #10 i_clk = ~i_clk;

    // decoder state as predicted
    t_phase      dec_phase;
    logic [15:0] hex_acc;
    logic        hex_err;
    logic [7:0]  held_digits [3];
    logic [9:0]  high_bits;
    logic        in_error;
    t_status     error_status;

    t_out_beat   expected_utf8 [$];
    logic [7:0]  step_bytes [$];
    logic [7:0]  frame_bytes [$];

    int          mismatch_count = 0;
    int          beats_sent     = 0;
    int          stall_left     = 0;
    logic        in_gaps        = 1'b0;
    logic        out_gaps       = 1'b0;
    t_out_beat   exp_beat;

    function void clear_decoder();
        dec_phase    = PH_IDLE;
        hex_acc      = '0;
        hex_err      = 1'b0;
        held_digits  = '{default: 8'h00};
        high_bits    = '0;
        in_error     = 1'b0;
        error_status = ST_OK;
    endfunction

    function void emit_byte(logic [7:0] b);
        if (step_bytes.size() < UE_MAX_OUT) step_bytes.push_back(b);
    endfunction

    function void take_hex(logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h41 + 8'd10);
        else hex_err = 1'b1;
        hex_acc = {hex_acc[11:0], d};
    endfunction

    function void emit_code_point(logic [20:0] cp);
        if (cp <= 21'h7F) begin
            emit_byte(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            emit_byte({3'b110, cp[10:6]});
            emit_byte({2'b10, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
            emit_byte({4'b1110, cp[15:12]});
            emit_byte({2'b10, cp[11:6]});
            emit_byte({2'b10, cp[5:0]});
        end else begin
            emit_byte({5'b11110, cp[20:18]});
            emit_byte({2'b10, cp[17:12]});
            emit_byte({2'b10, cp[11:6]});
            emit_byte({2'b10, cp[5:0]});
        end
    endfunction

    function void fail_with(t_status code);
        in_error     = 1'b1;
        error_status = code;
        dec_phase    = PH_IDLE;
    endfunction

    function void plain_char(logic [7:0] c);
        if (c == CH_BSLASH) dec_phase = PH_BS;
        else emit_byte(c);
    endfunction

    function void predict_utf8(t_in_beat beat);
        logic [7:0] c;
        int         held_n;
        int         k;
        c = beat.in_byte;
        step_bytes.delete();
        if (!in_error) begin
            case (dec_phase)
                PH_IDLE: plain_char(c);
                PH_BS: begin
                    if (c == CH_U) begin
                        dec_phase = PH_D1A;
                        hex_acc   = '0;
                        hex_err   = 1'b0;
                    end else begin
                        emit_byte(CH_BSLASH);
                        dec_phase = PH_IDLE;
                        plain_char(c);
                    end
                end
                PH_D1A, PH_D1B, PH_D1C: begin
                    take_hex(c);
                    held_digits[dec_phase - PH_D1A] = c;
                    dec_phase = t_phase'(dec_phase + 1);
                end
                PH_D1D: begin
                    take_hex(c);
                    if (hex_err) begin
                        fail_with(ST_ESC);
                    end else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                        high_bits = hex_acc[9:0];
                        dec_phase = PH_WBS;
                    end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                        fail_with(ST_ESC);
                    end else begin
                        emit_code_point({5'd0, hex_acc});
                        dec_phase = PH_IDLE;
                    end
                end
                PH_WBS: begin
                    if (c == CH_BSLASH) dec_phase = PH_WU;
                    else fail_with(ST_ESC);
                end
                PH_WU: begin
                    if (c == CH_U) begin
                        dec_phase = PH_D2A;
                        hex_acc   = '0;
                        hex_err   = 1'b0;
                    end else begin
                        fail_with(ST_ESC);
                    end
                end
                PH_D2A, PH_D2B, PH_D2C: begin
                    take_hex(c);
                    dec_phase = t_phase'(dec_phase + 1);
                end
                PH_D2D: begin
                    take_hex(c);
                    if (hex_err || hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                        fail_with(ST_PAIR);
                    end else begin
                        emit_code_point({1'b0, high_bits, hex_acc[9:0]} + 21'h10000);
                        dec_phase = PH_IDLE;
                    end
                end
                default: dec_phase = PH_IDLE;
            endcase
        end

        if (beat.in_last && !in_error) begin
            if (dec_phase == PH_BS) begin
                emit_byte(CH_BSLASH);
            end else if (dec_phase >= PH_D1A && dec_phase <= PH_D1D) begin
                emit_byte(CH_BSLASH);
                emit_byte(CH_U);
                held_n = dec_phase - PH_D1A;
                for (k = 0; k < held_n && k < 3; k++) emit_byte(held_digits[k]);
            end else if (dec_phase != PH_IDLE) begin
                fail_with(ST_ESC);
            end
        end

        if (beat.in_last && in_error) begin
            expected_utf8.push_back(t_out_beat'{8'h00, 1'b0, error_status, 1'b1});
        end else if (beat.in_last && step_bytes.size() == 0) begin
            expected_utf8.push_back(t_out_beat'{8'h00, 1'b0, ST_OK, 1'b1});
        end else begin
            for (k = 0; k < step_bytes.size(); k++)
                expected_utf8.push_back(t_out_beat'{step_bytes[k], 1'b1, ST_OK,
                    beat.in_last && (k == step_bytes.size() - 1)});
        end
        if (beat.in_last) clear_decoder();
    endfunction

    // result beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_utf8.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result beat: byte %02h valid %0b status %0d last %0b",
                             o_out_data.out_byte, o_out_data.out_valid,
                             o_out_data.status, o_out_data.out_last);
                mismatch_count++;
            end else begin
                exp_beat = expected_utf8.pop_front();
                if (o_out_data.out_byte !== exp_beat.out_byte
                        || o_out_data.out_valid !== exp_beat.out_valid
                        || o_out_data.status !== exp_beat.status
                        || o_out_data.out_last !== exp_beat.out_last) begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected byte %02h valid %0b status %0d last %0b, %s",
                                 exp_beat.out_byte, exp_beat.out_valid, exp_beat.status,
                                 exp_beat.out_last,
                                 $sformatf("got byte %02h valid %0b status %0d last %0b",
                                           o_out_data.out_byte, o_out_data.out_valid,
                                           o_out_data.status, o_out_data.out_last));
                    mismatch_count++;
                end
            end
        end
    end

    // random output stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || !out_gaps) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_beat(logic [7:0] b, logic l);
        t_in_beat beat;
        beat.in_byte = b;
        beat.in_last = l;
        if (in_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_utf8(beat);
        beats_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes.delete();
    endtask

    task automatic send_text(string s);
        foreach (s[i]) frame_bytes.push_back(s[i]);
        send_frame();
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_utf8.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] d);
        if (d < 4'd10) return 8'h30 + d;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 8'd10;
    endfunction

    function automatic logic [15:0] random_bmp();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic void push_escape(logic [15:0] v);
        frame_bytes.push_back(CH_BSLASH);
        frame_bytes.push_back(CH_U);
        frame_bytes.push_back(hex_char(v[15:12]));
        frame_bytes.push_back(hex_char(v[11:8]));
        frame_bytes.push_back(hex_char(v[7:4]));
        frame_bytes.push_back(hex_char(v[3:0]));
    endfunction

    function automatic void spoil_digit();
        frame_bytes[frame_bytes.size() - 1 - $urandom_range(0, 3)] = 8'($urandom_range(1, 255));
    endfunction

    function automatic void add_token();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4: frame_bytes.push_back(8'($urandom_range(1, 255)));
            5, 6, 7, 8: push_escape(random_bmp());
            9, 10: begin
                push_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                push_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            11: begin
                push_escape(random_bmp());
                spoil_digit();
            end
            12: begin
                push_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                case ($urandom_range(0, 3))
                    0: frame_bytes.push_back(8'($urandom_range(1, 255)));
                    1: begin
                        frame_bytes.push_back(CH_BSLASH);
                        frame_bytes.push_back(8'($urandom_range(1, 255)));
                    end
                    2: push_escape(random_bmp());
                    default: begin
                        push_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
                        spoil_digit();
                    end
                endcase
            end
            13: begin
                frame_bytes.push_back(CH_BSLASH);
                frame_bytes.push_back(8'($urandom_range(1, 255)));
            end
            14: push_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
            default: push_escape(16'($urandom_range(0, 16'hFFFF)));
        endcase
    endfunction

    function automatic void push_short_digits(int n);
        repeat (n) begin
            if ($urandom_range(0, 2) != 0) frame_bytes.push_back(hex_char(4'($urandom)));
            else frame_bytes.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    function automatic void build_frame();
        int n_tok;
        int k;
        n_tok = $urandom_range(1, 5);
        repeat (n_tok) add_token();
        case ($urandom_range(0, 5))
            0: begin
                frame_bytes.push_back(CH_BSLASH);
                frame_bytes.push_back(CH_U);
                push_short_digits($urandom_range(0, 3));
            end
            1: frame_bytes.push_back(CH_BSLASH);
            2: begin
                push_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                k = $urandom_range(0, 5);
                if (k >= 1) frame_bytes.push_back(CH_BSLASH);
                if (k >= 2) begin
                    frame_bytes.push_back(CH_U);
                    push_short_digits(k - 2);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic test_plain_bytes();
        frame_bytes = '{8'h01};
        send_frame();
        frame_bytes = '{8'hFF, 8'h80, 8'h41};
        send_frame();
    endtask

    task automatic test_escapes();
        send_text("\\u007f\\u0080");
        send_text("\\u07FF\\uFFFF");
    endtask

    task automatic test_surrogate_pairs();
        send_text("\\uD83D\\uDE00");
    endtask

    task automatic test_literal_tails();
        send_text("\\");
        send_text("\\u12");
        send_text("\\q\\\\");
    endtask

    task automatic test_error_frames();
        send_text("\\uDC00");
        send_text("\\uD800x");
        send_text("\\uD800\\u0041");
        send_text("\\u12G4ab");
    endtask

    task automatic test_random_frames(int target, logic vary_gaps);
        int goal;
        goal = beats_sent + target;
        while (beats_sent < goal) begin
            if (vary_gaps) begin
                in_gaps  = $urandom_range(0, 3) != 0;
                out_gaps = $urandom_range(0, 3) != 0;
            end
            build_frame();
            send_frame();
        end
    endtask

    task automatic test_drain_pause();
        build_frame();
        send_frame();
        wait_drained();
        build_frame();
        send_frame();
    endtask

    task automatic test_steady_stream();
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        test_random_frames(15, 1'b0);
    endtask

    initial begin
        int guard;
        clear_decoder();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        in_gaps  = 1'b1;
        out_gaps = 1'b1;

        test_plain_bytes();
        test_escapes();
        test_surrogate_pairs();
        test_literal_tails();
        test_error_frames();
        test_random_frames(20, 1'b1);
        test_drain_pause();
        test_steady_stream();

        i_in_valid <= 1'b0;
        for (guard = 0; guard < 20000 && expected_utf8.size() != 0; guard++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_utf8.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
